// ----- hw/rtl/ps2md_pkg.sv -----
// Shared types, constants and codes of the PS/2 mouse packet decoder.
package ps2md_pkg;

  // Default cursor coordinate width and packet queue depth
  localparam int unsigned POS_BITS_DEF    = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
  localparam int unsigned           CURSOR_X_RST      = 400;
  localparam int unsigned           CURSOR_Y_RST      = 300;

  // Bits of the first packet byte
  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned XSIGN_BIT = 4;
  localparam int unsigned YSIGN_BIT = 5;

  // Number of buttons reported
  localparam int unsigned NUM_BUTTONS = 3;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_code_e;

  // A decoded packet as it travels from front to back
  typedef struct packed {
    logic signed [8:0]        delta_x;
    logic signed [9:0]        delta_y;
    logic [NUM_BUTTONS-1:0]   buttons;
  } pkt_t;

endpackage

// ----- hw/rtl/ps2md_byte_if.sv -----
// Handshake channel carrying received mouse bytes.
interface ps2md_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/ps2md_event_if.sv -----
// Handshake channel carrying decoded mouse events.
interface ps2md_event_if import ps2md_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [1:0]          event_code;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic signed [8:0]   delta_x;
  logic signed [9:0]   delta_y;
  logic [1:0]          button_index;
  logic [2:0]          button_bits;
  logic                last_event;

  modport source (output valid, output event_code, output pos_x, output pos_y,
                  output delta_x, output delta_y, output button_index,
                  output button_bits, output last_event, input ready);
  modport sink   (input valid, input event_code, input pos_x, input pos_y,
                  input delta_x, input delta_y, input button_index,
                  input button_bits, input last_event, output ready);
endinterface

// ----- hw/rtl/ps2md_front.sv -----
// Front end: gathers bytes into packets, checks sync, decodes deltas and buttons.
module ps2md_front import ps2md_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ps2md_byte_if.sink    byte_i,
  output logic          push_o,
  output pkt_t          push_pkt_o,
  input  logic          full_i
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] b0_q, b1_q;
  logic       accept;
  logic       last_byte;
  logic signed [8:0] dy_raw;

  // Only the third byte needs room in the queue
  assign last_byte    = (phase_q == 2'd2);
  assign byte_i.ready = !last_byte || !full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // Phase counter
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = last_byte ? 2'd0 : phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Held bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == 2'd0) begin
      b0_q <= byte_i.rx_byte;
    end
    if (accept && phase_q == 2'd1) begin
      b1_q <= byte_i.rx_byte;
    end
  end

  // Decode: 9-bit deltas with sign from byte 0, Y inverted
  assign dy_raw = $signed({b0_q[YSIGN_BIT], byte_i.rx_byte});

  always_comb begin
    push_pkt_o.delta_x = $signed({b0_q[XSIGN_BIT], b1_q});
    push_pkt_o.delta_y = -(10'(dy_raw));
    push_pkt_o.buttons = b0_q[NUM_BUTTONS-1:0];
  end

  // Packets without the sync bit are dropped here
  assign push_o = accept && last_byte && b0_q[SYNC_BIT];

endmodule

// ----- hw/rtl/ps2md_fifo.sv -----
// Short packet queue between front and back end.
module ps2md_fifo import ps2md_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t push_pkt_i,
  output logic full_o,
  input  logic pop_i,
  output pkt_t pop_pkt_o,
  output logic nempty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pkt_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign nempty_o  = (count_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && nempty_o;
  assign pop_pkt_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

endmodule

// ----- hw/rtl/ps2md_back.sv -----
// Back end: screen limits, cursor update and event sequencing into the output register.
module ps2md_back import ps2md_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  pop_o,
  input  pkt_t                  pop_pkt_i,
  input  logic                  nempty_i,
  ps2md_event_if.source         event_o
);

  localparam logic [16:0] CAP = 17'(1) << POS_BITS;

  // Screen size to highest coordinate
  function automatic logic [POS_BITS-1:0] size_limit(logic [CFG_DATA_W-1:0] size);
    logic [POS_BITS-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else if (17'(size) > CAP) begin
      lim = '1;
    end else begin
      lim = POS_BITS'(size - 1'b1);
    end
    return lim;
  endfunction

  // Saturating move
  function automatic logic [POS_BITS-1:0] clamp_move(logic [POS_BITS-1:0] pos,
                                                     logic signed [9:0] delta,
                                                     logic [POS_BITS-1:0] lim);
    logic signed [POS_BITS+1:0] sum;
    logic [POS_BITS-1:0]        res;
    sum = $signed({2'b00, pos}) + (POS_BITS + 2)'(delta);
    if (sum < 0) begin
      res = '0;
    end else if (sum[POS_BITS:0] > {1'b0, lim}) begin
      res = lim;
    end else begin
      res = sum[POS_BITS-1:0];
    end
    return res;
  endfunction

  logic [POS_BITS-1:0] lim_x_q, lim_x_d, lim_y_q, lim_y_d;
  logic [POS_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [POS_BITS-1:0] new_lim;
  logic signed [8:0]   dx_q, dx_d;
  logic signed [9:0]   dy_q, dy_d;
  logic [2:0]          btn_q, btn_d;
  logic [2:0]          chg_q, chg_d;
  logic                active_q, active_d;
  logic                move_pend_q, move_pend_d;
  logic [2:0]          low_oh, chg_rest;
  logic [1:0]          low_idx;
  logic                load_out;

  // Output register
  logic                out_valid_q, out_valid_d;
  event_code_e         out_code_q, out_code_d;
  logic [1:0]          out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;
  logic [POS_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic signed [8:0]   out_dx_q, out_dx_d;
  logic signed [9:0]   out_dy_q, out_dy_d;
  logic [2:0]          out_btn_q, out_btn_d;

  assign new_lim  = size_limit(cfg_data_i);
  assign pop_o    = !active_q && nempty_i;
  assign load_out = !out_valid_q || event_o.ready;

  // Lowest changed button still to report
  assign low_oh   = chg_q & (~chg_q + 3'd1);
  assign chg_rest = chg_q & ~low_oh;

  always_comb begin
    case (low_oh)
      3'b010:  low_idx = 2'd1;
      3'b100:  low_idx = 2'd2;
      default: low_idx = 2'd0;
    endcase
  end

  // Config, packet load and event sequencing
  always_comb begin
    lim_x_d     = lim_x_q;
    lim_y_d     = lim_y_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    btn_d       = btn_q;
    chg_d       = chg_q;
    active_d    = active_q;
    move_pend_d = move_pend_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_dx_d    = out_dx_q;
    out_dy_d    = out_dy_q;
    out_btn_d   = out_btn_q;

    // Emit the next event of the current packet
    if (load_out) begin
      out_valid_d = active_q;
      out_x_d     = cur_x_q;
      out_y_d     = cur_y_q;
      out_dx_d    = dx_q;
      out_dy_d    = dy_q;
      out_btn_d   = btn_q;
      if (active_q) begin
        if (move_pend_q) begin
          out_code_d  = EV_MOVE;
          out_idx_d   = 2'd0;
          out_last_d  = (chg_q == '0);
          move_pend_d = 1'b0;
          active_d    = (chg_q != '0);
        end else begin
          out_code_d  = ((btn_q & low_oh) != '0) ? EV_PRESS : EV_RELEASE;
          out_idx_d   = low_idx;
          out_last_d  = (chg_rest == '0);
          chg_d       = chg_rest;
          active_d    = (chg_rest != '0);
        end
      end
    end

    // Take the next packet from the queue
    if (pop_o) begin
      dx_d        = pop_pkt_i.delta_x;
      dy_d        = pop_pkt_i.delta_y;
      btn_d       = pop_pkt_i.buttons;
      chg_d       = btn_q ^ pop_pkt_i.buttons;
      active_d    = 1'b1;
      move_pend_d = 1'b1;
      cur_x_d     = clamp_move(cur_x_q, 10'(pop_pkt_i.delta_x), lim_x_q);
      cur_y_d     = clamp_move(cur_y_q, pop_pkt_i.delta_y, lim_y_q);
    end

    // Register writes clamp the matching coordinate at once
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH: begin
          lim_x_d = new_lim;
          cur_x_d = clamp_move(cur_x_q, '0, new_lim);
        end
        REG_SCREEN_HEIGHT: begin
          lim_y_d = new_lim;
          cur_y_d = clamp_move(cur_y_q, '0, new_lim);
        end
        default: begin
        end
      endcase
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x_q     <= size_limit(SCREEN_WIDTH_RST);
      lim_y_q     <= size_limit(SCREEN_HEIGHT_RST);
      cur_x_q     <= POS_BITS'(CURSOR_X_RST);
      cur_y_q     <= POS_BITS'(CURSOR_Y_RST);
      btn_q       <= '0;
      chg_q       <= '0;
      active_q    <= 1'b0;
      move_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lim_x_q     <= lim_x_d;
      lim_y_q     <= lim_y_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      btn_q       <= btn_d;
      chg_q       <= chg_d;
      active_q    <= active_d;
      move_pend_q <= move_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    out_code_q <= out_code_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_dx_q   <= out_dx_d;
    out_dy_q   <= out_dy_d;
    out_btn_q  <= out_btn_d;
  end

  assign event_o.valid        = out_valid_q;
  assign event_o.event_code   = out_code_q;
  assign event_o.pos_x        = out_x_q;
  assign event_o.pos_y        = out_y_q;
  assign event_o.delta_x      = out_dx_q;
  assign event_o.delta_y      = out_dy_q;
  assign event_o.button_index = out_idx_q;
  assign event_o.button_bits  = out_btn_q;
  assign event_o.last_event   = out_last_q;

`ifndef SYNTHESIS
  // No pending events once the packet is finished
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (chg_q == '0) && !move_pend_q)
    else $error("idle back end holds pending events");

  // A freshly applied packet leaves the cursor inside the screen
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !cfg_we_i |=> (cur_x_q <= lim_x_q) && (cur_y_q <= lim_y_q))
    else $error("cursor outside screen after packet");

  // The first event after a packet load is the move event
  a_move_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o ##1 load_out |=> out_valid_q && (out_code_q == EV_MOVE))
    else $error("packet did not open with a move event");

  // Press and release events agree with the reported button state
  a_press_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_code_q == EV_PRESS) |-> out_btn_q[out_idx_q])
    else $error("press event with button released");

  a_release_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_code_q == EV_RELEASE) |-> !out_btn_q[out_idx_q])
    else $error("release event with button held");
`endif

endmodule

// ----- hw/rtl/ps2_mouse_packet_decoder.sv -----
// Top level of the PS/2 mouse three-byte packet decoder.
//
// byte_i takes mouse bytes in packet order, one item per handshake (valid and
// ready high at a rising edge). event_o gives one item per event: a move event
// for every packet whose first byte has the sync bit set, then a press or
// release event for each button that changed, left, right, middle; last_event
// marks the final item of a packet. Packets without the sync bit are dropped.
// cfg_we_i/cfg_idx_i/cfg_data_i write the screen width (index 0) and height
// (index 1); a write clamps the matching cursor coordinate straight away.
// The move event reaches the output register via the queue and the back end's
// packet registers. Throughput: the front end takes one byte per cycle unless
// the queue is full at a third byte; the back end loads a packet only when
// idle, then emits its events one per cycle while the receiver takes them.
// The packet queue lets bytes keep flowing while events wait; when the queue
// and output register fill up under a stalled receiver, ready on byte_i drops
// on the third byte of a packet. Reset clears the byte phase and queue,
// sets the cursor to (400, 300), buttons released, screen 1024 x 768.
module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
  parameter int unsigned POS_BITS    = POS_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ps2md_byte_if.sink            byte_i,
  ps2md_event_if.source         event_o
);

  logic push, full, pop, nempty;
  pkt_t push_pkt, pop_pkt;

  ps2md_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .push_o     (push),
    .push_pkt_o (push_pkt),
    .full_i     (full)
  );

  ps2md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (full),
    .pop_i      (pop),
    .pop_pkt_o  (pop_pkt),
    .nempty_o   (nempty)
  );

  ps2md_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pop_o      (pop),
    .pop_pkt_i  (pop_pkt),
    .nempty_i   (nempty),
    .event_o    (event_o)
  );

endmodule
